/* src/tcfc_pkg.sv */
// ----------------------------------------------------------------------------
// tcfc_pkg: shared types and constants for the typed compare filter counter
// Value type and compare codes, order codes, count width.
// ----------------------------------------------------------------------------
package tcfc_pkg;

	localparam int CountW = 23;
	localparam int ValW = 64;

	typedef enum logic [3:0] {
		VT_U8 = 4'd0, VT_S8 = 4'd1, VT_U16 = 4'd2, VT_S16 = 4'd3,
		VT_U32 = 4'd4, VT_S32 = 4'd5, VT_S64 = 4'd6, VT_F32 = 4'd7,
		VT_F64 = 4'd8
	} vtype_t;

	typedef enum logic [1:0] {
		CMP_EQ = 2'd0, CMP_LT = 2'd1, CMP_GT = 2'd2, CMP_NE = 2'd3
	} cmp_t;

	// register indexes
	typedef enum logic [1:0] {
		REG_TYPE = 2'd0, REG_CMP = 2'd1, REG_PREV = 2'd2, REG_TARGET = 2'd3
	} reg_idx_t;

	// ordering result of one typed compare
	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
		logic un;   // unordered or unused type
	} order_t;

	typedef struct packed {
		logic [3:0] vtype;
		logic [1:0] cmp;
		logic       use_prev;
	} cfg_t;

endpackage

/* src/typed_compare_filter_counter.sv */
// ----------------------------------------------------------------------------
// typed_compare_filter_counter: typed value search filter with match count
// Compares each element with a target or its previous value, counts matches.
// ----------------------------------------------------------------------------
// Request to result: input reg, then result reg. Throughput: one request
// per cycle when not stalled; compare and count sit between the input
// register and the result register, the counter add sets the loop.
// A full result register accepts a new request while the output is taken.
// Reset: arst_n clears the config registers, the match count and all valid flags.
module typed_compare_filter_counter import tcfc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [135:0]        s_tdata,   // element_value, previous_value, valid_in
	input  logic                s_tlast,   // last_element
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [23:0]         m_tdata,   // valid_out, match_total
	output logic                m_tlast    // page_done
);
	cfg_t            cfg_q;
	logic [ValW-1:0] target_q;

	// input stage
	logic            v_s1;
	logic [ValW-1:0] elem_s1, prev_s1;
	logic            cand_s1, last_s1;
	// result stage
	logic              v_s2;
	logic              hit_s2, last_s2;
	logic [CountW-1:0] total_s2;

	logic            adv1, take;
	order_t          ord;
	logic            rel, hit;
	logic [CountW-1:0] total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
			target_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TYPE:   cfg_q.vtype <= cfg_data[3:0];
				REG_CMP:    cfg_q.cmp <= cfg_data[1:0];
				REG_PREV:   cfg_q.use_prev <= cfg_data[0];
				REG_TARGET: target_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 2 moves when empty or its result is taken; stage 1 when stage 2 moves
	assign adv1     = !v_s2 || m_tready;
	assign s_tready = !v_s1 || adv1;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			elem_s1 <= s_tdata[63:0];
			prev_s1 <= s_tdata[127:64];
			cand_s1 <= s_tdata[128];
			last_s1 <= s_tlast;
		end
	end

	tcfc_compare u_cmp (
		.vtype(cfg_q.vtype),
		.a    (elem_s1),
		.b    (cfg_q.use_prev ? prev_s1 : target_q),
		.ord  (ord)
	);

	always_comb begin
		unique case (cmp_t'(cfg_q.cmp))
			CMP_EQ:  rel = ord.eq;
			CMP_LT:  rel = ord.lt;
			CMP_GT:  rel = ord.gt;
			CMP_NE:  rel = !ord.eq && (ord.lt || ord.gt || ord.un) && !(ord.un && 1'b0);
			default: rel = 1'b0;
		endcase
	end

	// an unused type gives un with no order; not-equal must then fail
	assign hit = cand_s1 && rel && !(ord.un && cfg_q.vtype > 4'(VT_F64));

	tcfc_counter u_cnt (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (v_s1 && adv1),
		.hit   (hit),
		.last  (last_s1),
		.total (total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv1) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && v_s1) begin
			hit_s2 <= hit;
			last_s2 <= last_s1;
			total_s2 <= total;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {total_s2, hit_s2};
	assign m_tlast  = last_s2;

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result lost under stall");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !v_s2 |=> v_s2) else $error("stage 1 did not advance");
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !cand_s1 |-> !hit) else $error("hit without candidate");
endmodule

/* src/tcfc_compare.sv */
// ----------------------------------------------------------------------------
// tcfc_compare: typed ordering of two raw 64-bit values
// Integer orders via sign flip, IEEE orders via sign-magnitude keys.
// ----------------------------------------------------------------------------
module tcfc_compare import tcfc_pkg::*; (
	input  logic [3:0]      vtype,
	input  logic [ValW-1:0] a,
	input  logic [ValW-1:0] b,
	output order_t          ord
);
	logic [ValW-1:0] ka, kb;
	logic            nan, zeros;
	logic [30:0]     a32m, b32m;
	logic [62:0]     a64m, b64m;

	always_comb begin
		a32m = a[30:0];
		b32m = b[30:0];
		a64m = a[62:0];
		b64m = b[62:0];
		nan = 1'b0;
		zeros = 1'b0;
		ka = '0;
		kb = '0;
		unique case (vtype)
			VT_U8: begin ka = {56'd0, a[7:0]}; kb = {56'd0, b[7:0]}; end
			VT_S8: begin
				ka = {56'd0, ~a[7], a[6:0]}; kb = {56'd0, ~b[7], b[6:0]};
			end
			VT_U16: begin ka = {48'd0, a[15:0]}; kb = {48'd0, b[15:0]}; end
			VT_S16: begin
				ka = {48'd0, ~a[15], a[14:0]}; kb = {48'd0, ~b[15], b[14:0]};
			end
			VT_U32: begin ka = {32'd0, a[31:0]}; kb = {32'd0, b[31:0]}; end
			VT_S32: begin
				ka = {32'd0, ~a[31], a[30:0]}; kb = {32'd0, ~b[31], b[30:0]};
			end
			VT_S64: begin ka = {~a[63], a[62:0]}; kb = {~b[63], b[62:0]}; end
			VT_F32: begin
				nan = (a32m > 31'h7F800000) || (b32m > 31'h7F800000);
				zeros = (a32m == '0) && (b32m == '0);
				ka = {32'd0, (a[31] ? ~a[31:0] : {1'b1, a[30:0]})};
				kb = {32'd0, (b[31] ? ~b[31:0] : {1'b1, b[30:0]})};
			end
			VT_F64: begin
				nan = (a64m > 63'h7FF0000000000000) || (b64m > 63'h7FF0000000000000);
				zeros = (a64m == '0) && (b64m == '0);
				ka = a[63] ? ~a : {1'b1, a[62:0]};
				kb = b[63] ? ~b : {1'b1, b[62:0]};
			end
			default: nan = 1'b1;
		endcase
		ord.un = nan;
		ord.eq = !nan && (zeros || ka == kb);
		ord.lt = !nan && !zeros && (ka < kb);
		ord.gt = !nan && !zeros && (ka > kb);
	end
endmodule

/* src/tcfc_counter.sv */
// ----------------------------------------------------------------------------
// tcfc_counter: per-page match counter
// Adds a hit, reports the total, clears after the last element.
// ----------------------------------------------------------------------------
module tcfc_counter import tcfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              hit,
	input  logic              last,
	output logic [CountW-1:0] total
);
	logic [CountW-1:0] count_q;

	assign total = count_q + CountW'(hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (step) begin
			count_q <= last ? '0 : total;
		end
	end

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> count_q == '0) else $error("count not cleared");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(count_q)) else $error("count moved without step");
	a_inc: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last && !hit |=> $stable(count_q)) else $error("count grew on miss");
endmodule

/* test/tb_typed_compare_filter_counter.sv */
// ----------------------------------------------------------------------------
// tb_typed_compare_filter_counter: self-checking bench for the search filter
// Drives element requests over the input stream, predicts the filter bit and
// running page count per request, and checks every result in order. A short
// table of directed rows opens the run, then randomized pages under random
// settings of type, compare and operand source follow.
// ----------------------------------------------------------------------------
module tb_typed_compare_filter_counter;
	import tcfc_pkg::*;

	localparam int WatchLimit = 4000;
	localparam int RandItems = 1850;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [63:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;
	logic         m_tlast;

	typed_compare_filter_counter DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	typedef struct packed {
		logic        hit;
		logic [22:0] total;
		logic        done;
	} match_t;

	// model copy of the registers and the page count
	logic [3:0]  cur_type;
	logic [1:0]  cur_cmp;
	logic        cur_prev;
	logic [63:0] cur_target;
	logic [22:0] hits_so_far;

	match_t expected_q[$];
	int     errors;
	bit     quiet;      // no idling in the closing stretch
	int     idle_cycles;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// order codes of one typed compare
	typedef enum int {ORD_LT, ORD_EQ, ORD_GT, ORD_UN} order_e;

	function automatic order_e order_keys(logic [63:0] a, logic [63:0] b);
		if (a < b) return ORD_LT;
		if (a > b) return ORD_GT;
		return ORD_EQ;
	endfunction

	function automatic logic [63:0] wmask(int w);
		return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
	endfunction

	function automatic order_e order_int(logic [63:0] a, logic [63:0] b, int w, bit sgn);
		logic [63:0] m, flip;
		m = wmask(w);
		flip = sgn ? (64'd1 << (w - 1)) : 64'd0;
		return order_keys((a & m) ^ flip, (b & m) ^ flip);
	endfunction

	// IEEE order on raw bits: NaN unordered, signed zeros equal
	function automatic order_e order_flt(logic [63:0] a, logic [63:0] b, int w, int mb);
		logic [63:0] m, sgn, mag, inf, ka, kb;
		m = wmask(w);
		sgn = 64'd1 << (w - 1);
		mag = m & ~sgn;
		inf = mag & ~wmask(mb);
		a &= m;
		b &= m;
		if ((a & mag) > inf || (b & mag) > inf) return ORD_UN;
		if ((a & mag) == 0 && (b & mag) == 0) return ORD_EQ;
		ka = (a & sgn) ? (~a & m) : (a | sgn);
		kb = (b & sgn) ? (~b & m) : (b | sgn);
		return order_keys(ka, kb);
	endfunction

	// one element through the filter: returns result, advances the page count
	function automatic match_t filter_element(logic [63:0] ev, logic [63:0] pv,
			logic vin, logic lst);
		logic [63:0] rhs;
		order_e o;
		bit known, rel;
		match_t r;
		rhs = cur_prev ? pv : cur_target;
		known = 1;
		case (cur_type)
			VT_U8:  o = order_int(ev, rhs, 8, 0);
			VT_S8:  o = order_int(ev, rhs, 8, 1);
			VT_U16: o = order_int(ev, rhs, 16, 0);
			VT_S16: o = order_int(ev, rhs, 16, 1);
			VT_U32: o = order_int(ev, rhs, 32, 0);
			VT_S32: o = order_int(ev, rhs, 32, 1);
			VT_S64: o = order_int(ev, rhs, 64, 1);
			VT_F32: o = order_flt(ev, rhs, 32, 23);
			VT_F64: o = order_flt(ev, rhs, 64, 52);
			default: begin
				known = 0;
				o = ORD_UN;
			end
		endcase
		case (cur_cmp)
			CMP_EQ: rel = (o == ORD_EQ);
			CMP_LT: rel = (o == ORD_LT);
			CMP_GT: rel = (o == ORD_GT);
			default: rel = (o != ORD_EQ);
		endcase
		r.hit = vin && known && rel;
		r.total = hits_so_far + r.hit;
		r.done = lst;
		hits_so_far = lst ? 23'd0 : r.total;
		return r;
	endfunction

	// one write, then a pause with cfg_we low so back-to-back writes never collide
	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TYPE: cur_type = val[3:0];
			REG_CMP:  cur_cmp = val[1:0];
			REG_PREV: cur_prev = val[0];
			default:  cur_target = val;
		endcase
		@(posedge clk);
	endtask

	// wait until every result is in, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// send one element; predicted result is queued at acceptance.
	// forced: a non-negative value is checked against the predicted filter bit.
	// tvalid stays high after acceptance so elements can follow back to back.
	task automatic send_element(logic [63:0] ev, logic [63:0] pv, logic vin,
			logic lst, int forced);
		match_t r;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, vin, pv, ev};
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		r = filter_element(ev, pv, vin, lst);
		if (forced >= 0 && r.hit != forced[0]) begin
			$display("%0t table row: expected hit %0d, predictor gives %0d",
				$time, forced, r.hit);
			errors++;
		end
		expected_q.push_back(r);
	endtask

	// output side: random stall bursts, compare each result with the oldest
	always @(posedge clk) begin
		match_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[0], m_tdata[23:1], m_tlast};
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (got !== want)
					$display("%0t mismatch: exp hit=%0d total=%0d done=%0d %s",
						$time, want.hit, want.total, want.done,
						$sformatf("got hit=%0d total=%0d done=%0d",
							got.hit, got.total, got.done));
				if (got !== want) errors++;
			end
		end
		if (idle_cycles > 0) begin
			idle_cycles <= idle_cycles - 1;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 6) == 0) begin
			idle_cycles <= $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	// watchdog: cycles without any request or result accepted
	int stuck;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck >= WatchLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// directed rows: register setting, then one element
	typedef struct {
		logic [3:0]  vt;
		logic [1:0]  cmp;
		logic        prev;
		logic [63:0] tgt;
		logic [63:0] ev;
		logic [63:0] pv;
		logic        vin;
		logic        lst;
		int          hit;   // -1 means predictor only
	} row_t;

	row_t rows[] = '{
		'{VT_U8,  CMP_EQ, 0, 64'h0,  64'h0, 64'h0, 1, 0, 1},          // after reset
		'{VT_U8,  CMP_EQ, 0, 64'h0,  64'h0, 64'h0, 0, 1, 0},          // not a candidate
		'{VT_U8,  CMP_GT, 0, 64'hFFFF_FFFF_FFFF_FF00, 64'hFF, 64'h0, 1, 0, 1}, // high bits ignored
		'{VT_S8,  CMP_LT, 0, 64'h7F, 64'h80, 64'h0, 1, 0, 1},
		'{VT_U16, CMP_NE, 1, 64'h0,  64'hFFFF, 64'h1_FFFF, 1, 0, 0},
		'{VT_S16, CMP_GT, 1, 64'h0,  64'h7FFF, 64'h8000, 1, 0, 1},
		'{VT_U32, CMP_LT, 0, 64'hFFFF_FFFF, 64'h0, 64'h0, 1, 0, 1},
		'{VT_S32, CMP_LT, 0, 64'h0,  64'h8000_0000, 64'h0, 1, 0, 1},
		'{VT_S64, CMP_GT, 0, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1, 0, 1},
		'{VT_F32, CMP_EQ, 0, 64'h8000_0000, 64'h0, 64'h0, 1, 0, 1}, // +0 == -0
		'{VT_F32, CMP_NE, 0, 64'h3F80_0000, 64'h7FC0_0000, 0, 1, 0, 1}, // NaN
		'{VT_F32, CMP_EQ, 0, 64'h7FC0_0000, 64'h7FC0_0000, 0, 1, 0, 0},
		'{VT_F32, CMP_LT, 0, 64'h7F80_0000, 64'hFF80_0000, 0, 1, 0, 1}, // -inf < +inf
		'{VT_F64, CMP_GT, 1, 64'h0, 64'hBFF0_0000_0000_0000, 64'hC000_0000_0000_0000, 1, 0, 1},
		'{VT_F64, CMP_LT, 0, 64'h7FF0_0000_0000_0001, 64'h0, 0, 1, 0, 0}, // NaN target
		'{4'd9,   CMP_NE, 0, 64'h1,  64'h0, 64'h0, 1, 0, 0},         // unused type
		'{4'd15,  CMP_EQ, 0, 64'h0,  64'h0, 64'h0, 1, 1, 0},
		'{VT_U8,  CMP_EQ, 0, 64'h0,  64'h0, 64'h0, 1, 1, 1}
	};

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// operand with a bias toward values that make typed compares interesting
	function automatic logic [63:0] pick_value(logic [63:0] near);
		case ($urandom_range(0, 7))
			0: return near;
			1: return near ^ (64'd1 << $urandom_range(0, 63));
			2: return near + $urandom_range(0, 2) - 1;
			3: return {$urandom(), 32'h7F80_0000 | ($urandom_range(0, 1) << 22)};
			4: return 64'h7FF0_0000_0000_0000 | $urandom_range(0, 1);
			5: return near ^ 64'h8000_0000_8000_8080;
			default: return rand64();
		endcase
	endfunction

	initial begin
		int n;
		logic [63:0] ev, pv;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TYPE;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		errors = 0;
		quiet = 0;
		idle_cycles = 0;
		cur_type = VT_U8;
		cur_cmp = CMP_EQ;
		cur_prev = 1'b0;
		cur_target = '0;
		hits_so_far = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (i > 0) begin
				drain();
				write_reg(REG_TYPE, rows[i].vt);
				write_reg(REG_CMP, rows[i].cmp);
				write_reg(REG_PREV, rows[i].prev);
				write_reg(REG_TARGET, rows[i].tgt);
			end
			send_element(rows[i].ev, rows[i].pv, rows[i].vin, rows[i].lst, rows[i].hit);
		end

		// random phases: new setting, then pages of well-formed elements
		n = 0;
		while (n < RandItems) begin
			drain();
			write_reg(REG_TYPE, $urandom_range(0, 12) < 10 ? $urandom_range(0, 8)
				: $urandom_range(9, 15));
			write_reg(REG_CMP, $urandom_range(0, 3));
			write_reg(REG_PREV, $urandom_range(0, 1));
			write_reg(REG_TARGET, pick_value(rand64()));
			if (n > RandItems - 200) quiet = 1;
			repeat ($urandom_range(20, 80)) begin
				pv = pick_value(cur_target);
				ev = pick_value(cur_prev ? pv : cur_target);
				send_element(ev, pv, $urandom_range(0, 5) != 0,
					$urandom_range(0, 15) == 0, -1);
				n++;
			end
		end

		drain();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
